/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the sequence gap detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Explicit clock and reset.
`define SGD_ASSERT_CR(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Module clock clk, reset rst.
`define SGD_ASSERT(lbl, prop, msg) \
  `SGD_ASSERT_CR(lbl, clk, rst, prop, msg)

`endif

/* src/seqgap_pkg.sv */
// ----------------------------------------------------------------------------
// Sequence gap detector package
// Shared constants, state encoding and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package seqgap_pkg;

  localparam int SEQ_SPACE = 64;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic record;
    logic start;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* src/seqgap_if.sv */
// ----------------------------------------------------------------------------
// Sequence gap detector channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface seqgap_in_if
  import seqgap_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [SEQ_W-1:0] seq_number;

  modport source (output valid, output func, output seq_number, input ready);
  modport sink   (input valid, input func, input seq_number, output ready);
endinterface

interface seqgap_out_if
  import seqgap_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] missing_seq;
  logic             none_missing;
  logic             last;

  modport source (output valid, output missing_seq, output none_missing, output last,
                  input ready);
  modport sink   (input valid, input missing_seq, input none_missing, input last,
                  output ready);
endinterface

`default_nettype wire

/* src/sequence_gap_detector.sv */
// Timing: a record item is taken only while idle; a query holds the input while it scans map
// entries 1 to highest_seq - 1, one map entry per cycle except while the result channel stalls.
// A found gap waits in a lookahead register until the next gap or the scan end loads it out.
// Throughput: one record per cycle while no query scan is running; queries are served one at a time.
// Reset: synchronous, active high; clears the map, highest number and result valid.
// ----------------------------------------------------------------------------
// Sequence gap detector
// Records received sequence numbers and reports missing ones on query.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_gap_detector
  import seqgap_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  seqgap_in_if.sink   items_in,
  seqgap_out_if.source results_out
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign items_in.ready = in_ready;

  seqgap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items_in.valid),
    .in_func  (items_in.func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  seqgap_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_seq           (items_in.seq_number),
    .out_valid        (results_out.valid),
    .out_ready        (results_out.ready),
    .out_missing_seq  (results_out.missing_seq),
    .out_none_missing (results_out.none_missing),
    .out_last         (results_out.last)
  );

endmodule

`default_nettype wire

/* src/seqgap_ctrl.sv */
// ----------------------------------------------------------------------------
// Sequence gap detector controller
// Sequences record items and the query scan over the received map.
// ----------------------------------------------------------------------------
`default_nettype none

module seqgap_ctrl
  import seqgap_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_func,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_QUERY) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.record = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_end) begin
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!(status.hit && status.pend_valid && !status.out_free)) begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/seqgap_dp.sv */
// ----------------------------------------------------------------------------
// Sequence gap detector datapath
// Received map, highest number, scan index, one-deep lookahead and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module seqgap_dp
  import seqgap_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic [SEQ_W-1:0] in_seq,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SEQ_W-1:0]      out_missing_seq,
  output logic                  out_none_missing,
  output logic                  out_last
);

  logic [SEQ_SPACE-1:0] received_map;
  logic [SEQ_W-1:0]     highest_seq;
  logic                 any_recorded;
  logic [SEQ_W-1:0]     scan_idx;
  logic                 pend_valid;
  logic [SEQ_W-1:0]     pend_seq;
  logic                 out_free;
  logic                 hit;
  logic                 out_load;
  logic [SEQ_W-1:0]     load_seq;
  logic                 load_none;
  logic                 load_last;

  assign hit      = !received_map[scan_idx];
  assign out_free = !out_valid || out_ready;

  assign status = '{
    scan_end:   !any_recorded || (scan_idx >= highest_seq),
    hit:        hit,
    pend_valid: pend_valid,
    out_free:   out_free
  };

  always_comb begin
    out_load  = 1'b0;
    load_seq  = pend_seq;
    load_none = 1'b0;
    load_last = 1'b0;
    if (cmd.finish) begin
      out_load  = 1'b1;
      load_last = 1'b1;
      if (!pend_valid) begin
        load_seq  = '0;
        load_none = 1'b1;
      end
    end else if (cmd.advance && hit && pend_valid) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_map <= '0;
      highest_seq  <= '0;
      any_recorded <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.record) begin
        received_map[in_seq] <= 1'b1;
        any_recorded         <= 1'b1;
        if (!any_recorded || in_seq > highest_seq) begin
          highest_seq <= in_seq;
        end
      end
      if (cmd.start || cmd.finish) begin
        pend_valid <= 1'b0;
      end else if (cmd.advance && hit) begin
        received_map[scan_idx] <= 1'b1;
        pend_valid             <= 1'b1;
      end
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_idx <= SEQ_W'(1);
    end else if (cmd.advance) begin
      scan_idx <= scan_idx + SEQ_W'(1);
    end
    if (cmd.advance && hit) begin
      pend_seq <= scan_idx;
    end
    if (out_load) begin
      out_missing_seq  <= load_seq;
      out_none_missing <= load_none;
      out_last         <= load_last;
    end
  end

  `SGD_ASSERT(a_adv_in_range, cmd.advance |-> !status.scan_end, "scan advanced past bound")
  `SGD_ASSERT(a_load_free, out_load |-> out_free, "result register overwritten")
  `SGD_ASSERT(a_finish_clears, cmd.finish |=> !pend_valid, "lookahead left after query")

endmodule

`default_nettype wire
